>>> design/morse_symbol_decoder_core_assert.svh
// Assertion macros for the Morse symbol decoder.
`ifndef MORSE_SYMBOL_DECODER_CORE_ASSERT_SVH
`define MORSE_SYMBOL_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MSD_ASSERT_IMPL(name, clock, resetn, ante, cons) \
  name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define MSD_ASSERT_NEXT(name, clock, resetn, ante, cons) \
  name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MSD_ASSERT_IMPL(name, clock, resetn, ante, cons)
`define MSD_ASSERT_NEXT(name, clock, resetn, ante, cons)
`endif
`endif

>>> design/msd_pkg.sv
package msd_pkg;

  localparam int LETTER_COUNT = 26;

  localparam logic [2:0] MAX_SYMBOLS = 3'd4;
  localparam logic [2:0] TOO_LONG    = 3'd5;

  localparam logic [7:0] CHAR_DOT   = 8'h2A;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_NONE  = 8'h00;

  // {length, symbols}; symbol k in bit k, dash is 1
  localparam logic [6:0] LETTER_CODES [LETTER_COUNT] = '{
    {3'd2, 4'b0010}, {3'd4, 4'b0001}, {3'd4, 4'b0101}, {3'd3, 4'b0001},
    {3'd1, 4'b0000}, {3'd4, 4'b0100}, {3'd3, 4'b0011}, {3'd4, 4'b0000},
    {3'd2, 4'b0000}, {3'd4, 4'b1110}, {3'd3, 4'b0101}, {3'd4, 4'b0010},
    {3'd2, 4'b0011}, {3'd2, 4'b0001}, {3'd3, 4'b0111}, {3'd4, 4'b0110},
    {3'd4, 4'b1011}, {3'd3, 4'b0010}, {3'd3, 4'b0000}, {3'd1, 4'b0001},
    {3'd3, 4'b0100}, {3'd4, 4'b1000}, {3'd3, 4'b0110}, {3'd4, 4'b1001},
    {3'd4, 4'b1101}, {3'd4, 4'b0011}
  };

  typedef struct packed {
    logic [3:0] sym;
    logic [2:0] len;
    logic       sp;
  } code_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       bad;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] cnt;
  } step_t;

  function automatic res_t flush_res(logic [3:0] sym, logic [2:0] len);
    res_t r;
    logic hit;
    r   = '{ch: CHAR_NONE, bad: 1'b1, last: 1'b0};
    hit = 1'b0;
    for (int i = 0; i < LETTER_COUNT; i++) begin
      if (LETTER_CODES[i] == {len, sym}) begin
        hit  = 1'b1;
        r.ch = CHAR_A + 8'(i);
      end
    end
    r.bad = ~hit;
    return r;
  endfunction

endpackage

>>> design/msd_decode.sv
module msd_decode (
  input  logic [7:0]    in_char,
  input  logic          in_eot,
  input  msd_pkg::code_t cur,
  output msd_pkg::code_t nxt,
  output msd_pkg::step_t step
);
  import msd_pkg::*;

  code_t app;
  res_t  ra;
  res_t  rb;
  logic  va;
  logic  vb;
  logic  is_sym;
  logic  is_ws;
  logic  is_dash;

  assign is_dash = (in_char == CHAR_DASH);
  assign is_sym  = (in_char == CHAR_DOT) || is_dash;
  assign is_ws   = (in_char == CHAR_SPACE) || ((in_char >= CHAR_TAB) && (in_char <= CHAR_CR));

  always_comb begin
    app    = cur;
    app.sp = 1'b0;
    if (cur.len < MAX_SYMBOLS) begin
      app.sym = cur.sym | (4'(is_dash) << cur.len[1:0]);
      app.len = cur.len + 3'd1;
    end else begin
      app.len = TOO_LONG;
    end
  end

  always_comb begin
    nxt = cur;
    ra  = '{ch: CHAR_NONE, bad: 1'b0, last: 1'b0};
    rb  = ra;
    va  = 1'b0;
    vb  = 1'b0;
    priority if (is_sym) begin
      nxt = app;
      if (in_eot) begin
        ra      = flush_res(app.sym, app.len);
        va      = 1'b1;
        nxt.sym = '0;
        nxt.len = '0;
      end
    end else if (is_ws) begin
      ra      = flush_res(cur.sym, cur.len);
      va      = (cur.len != 3'd0);
      nxt.sym = '0;
      nxt.len = '0;
      if (in_char == CHAR_SPACE) begin
        if (cur.sp) begin
          rb.ch  = CHAR_SPACE;
          vb     = 1'b1;
          nxt.sp = 1'b0;
        end else begin
          nxt.sp = 1'b1;
        end
      end else begin
        rb.ch  = in_char;
        vb     = 1'b1;
        nxt.sp = 1'b0;
      end
      if (in_eot) begin
        nxt.sp = 1'b0;
      end
    end else begin
      ra.ch  = in_char;
      va     = 1'b1;
      nxt.sp = 1'b0;
      if (in_eot) begin
        rb      = flush_res(cur.sym, cur.len);
        vb      = (cur.len != 3'd0);
        nxt.sym = '0;
        nxt.len = '0;
      end
    end
  end

  always_comb begin
    step.cnt = 2'(va) + 2'(vb);
    if (va) begin
      step.r0 = ra;
      step.r1 = rb;
    end else begin
      step.r0 = rb;
      step.r1 = rb;
    end
    step.r0.last = (step.cnt == 2'd1);
    step.r1.last = 1'b1;
  end

endmodule

>>> design/msd_outq.sv
module msd_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  msd_pkg::step_t step,
  output logic           can_load,
  input  logic           out_ready,
  output logic           out_valid,
  output msd_pkg::res_t  head
);
  import msd_pkg::*;

  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  res_t       slot0_r;
  res_t       slot0_nxt;
  res_t       slot1_r;
  res_t       slot1_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign head      = slot0_r;

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    priority if (load) begin
      cnt_nxt   = step.cnt;
      slot0_nxt = step.r0;
      slot1_nxt = step.r1;
    end else if (pop) begin
      cnt_nxt   = cnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end else begin
      cnt_nxt   = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

>>> design/morse_symbol_decoder_core.sv
// Morse symbol decoder core.
// Input channel: in_valid/in_ready carry one text byte (in_char) and the
// end-of-text mark (in_end_of_text). Dots ('*') and dashes ('-') build a
// code of up to four symbols; whitespace or end of text looks it up.
// Output channel: out_valid/out_ready carry out_char, out_bad_code and
// out_run_end; out_run_end marks the last result of a given byte.
// A byte gives zero, one or two results.
// An accepted byte is held in the input register; its results are written
// into a two-entry result queue once the queue can take them, and out_valid
// rises from the edge that writes them.
// Throughput: one byte per cycle while out_ready is high and each byte
// gives at most one result; a queue holding two results takes no new byte
// until the first of them has been taken.
// Stall: when out_ready is low the queue holds, the input register fills,
// and in_ready drops until the queue has room again.
// Reset (rst_n low at a clock edge): code, space flag and both channels
// are cleared; no result is pending afterward.
`include "morse_symbol_decoder_core_assert.svh"

module morse_symbol_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_bad_code,
  output logic       out_run_end
);
  import msd_pkg::*;

  logic       in_vld_r;
  logic       in_vld_nxt;
  logic [7:0] in_char_r;
  logic       in_eot_r;
  code_t      code_r;
  code_t      code_nxt;
  code_t      code_dec;
  step_t      step;
  res_t       head;
  logic       can_load;
  logic       fire;
  logic       in_acc;

  assign fire     = in_vld_r && can_load;
  assign in_ready = !in_vld_r || fire;
  assign in_acc   = in_valid && in_ready;

  msd_decode u_decode (
    .in_char (in_char_r),
    .in_eot  (in_eot_r),
    .cur     (code_r),
    .nxt     (code_dec),
    .step    (step)
  );

  msd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .step      (step),
    .can_load  (can_load),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .head      (head)
  );

  assign out_char     = head.ch;
  assign out_bad_code = head.bad;
  assign out_run_end  = head.last;

  always_comb begin
    in_vld_nxt = in_vld_r;
    code_nxt   = code_r;
    if (fire) begin
      in_vld_nxt = 1'b0;
      code_nxt   = code_dec;
    end
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      code_r   <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      code_r   <= code_nxt;
    end
    if (in_acc) begin
      in_char_r <= in_char;
      in_eot_r  <= in_end_of_text;
    end
  end

  `MSD_ASSERT_IMPL(a_len_range, clk, rst_n, 1'b1, code_r.len <= TOO_LONG)
  `MSD_ASSERT_IMPL(a_space_no_code, clk, rst_n, code_r.sp, code_r.len == 3'd0)
  `MSD_ASSERT_NEXT(a_pair_follows, clk, rst_n, out_valid && !out_run_end, out_valid)

endmodule
